@@ src/msbbuf_pkg.sv @@
// Shared types and constants for the MSB-first bit stream buffer.
`default_nettype none

package msbbuf_pkg;

  localparam int unsigned CntW   = 6;   // bit_count field
  localparam int unsigned CapW   = 13;  // capacity register
  localparam int unsigned BytesW = 13;  // bytes_in_call field
  localparam int unsigned WordW  = 32;  // result word
  localparam int unsigned ProdW  = CntW + BytesW;

  localparam logic [CapW-1:0] CapReset = 13'd4096;

  localparam logic ModeAppend = 1'b0;
  localparam logic ModeRead   = 1'b1;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_EVAL  = 7'b0000100,
    ST_WRITE = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

endpackage : msbbuf_pkg

`default_nettype wire

@@ src/msbbuf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msbbuf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : msbbuf_ram

`default_nettype wire

@@ src/msb_first_bit_stream_buffer_core.sv @@
// Top level of the MSB-first bit stream buffer: sequencer, pointers, bit-serial store access.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | mode, data_byte, bit_count, first_of_call,
//          |           |                        | bytes_in_call
//  out     | source    | out_valid_o/out_stall_i| status, word
//  cfg     | sink      | capacity_bits_we_i     | capacity_bits_i
//
//  Append: PREP, EVAL, WRITE per bit, DONE. Read: PREP, EVAL, READ per bit, DRAIN, DONE. A
//  rejected or empty word skips to DONE. The store is 1 bit wide, so the bit loop sets the rate.
//  One word is in flight at a time; in_stall_o is low only in idle. A finished result
//  waits in the sequencer while the output register is still stalled.
//  Reset clears pointers and the call-reject flag and sets the capacity to 4096. The bit store is
//  not cleared: reads never reach bits at or above the write pointer.
`default_nettype none

module msb_first_bit_stream_buffer_core
  import msbbuf_pkg::*;
#(
  parameter int unsigned STORE_BITS    = 4096,
  parameter int unsigned MAX_READ_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              capacity_bits_we_i,
  input  wire logic [CapW-1:0]   capacity_bits_i,
  // input words
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic [CntW-1:0]   bit_count_i,
  input  wire logic              first_of_call_i,
  input  wire logic [BytesW-1:0] bytes_in_call_i,
  // result words
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   status_o,
  output logic [WordW-1:0]       word_o
);

  localparam int unsigned PtrW  = $clog2(STORE_BITS + 1);
  localparam int unsigned AddrW = $clog2(STORE_BITS);
  localparam int unsigned SumW  = ((PtrW > ProdW) ? PtrW : ProdW) + 1;

  state_e state_q, state_d;

  logic [CapW-1:0]   cap_q;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic              rej_q, rej_d;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;

  // item payload and working registers (no reset)
  logic              mode_q;
  logic [7:0]        data_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              first_q;
  logic [BytesW-1:0] nbytes_q;
  logic [ProdW-1:0]  prod_q;
  logic              err_q, err_d;
  logic [WordW-1:0]  acc_q;
  logic              status_q;
  logic [WordW-1:0]  word_q;

  logic              in_acc;
  logic              out_free;
  logic              ram_we;
  logic              ram_wbit;
  logic              ram_rbit;
  logic [CntW-1:0]   pos;
  logic [SumW-1:0]   cap_eff;
  logic [SumW-1:0]   need_call;
  logic [SumW-1:0]   need_byte;
  logic [SumW-1:0]   need_read;
  logic              call_over;
  logic              rej_now;
  logic              byte_over;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // effective capacity is the register limited to the store size
  assign cap_eff = (SumW'(cap_q) > SumW'(STORE_BITS)) ? SumW'(STORE_BITS) : SumW'(cap_q);

  assign need_call = SumW'(wp_q) + SumW'(prod_q);
  assign need_byte = SumW'(wp_q) + SumW'(cnt_q);
  assign need_read = SumW'(rp_q) + SumW'(cnt_q);
  assign call_over = need_call > cap_eff;
  // a first byte re-evaluates the call; later bytes inherit the flag
  assign rej_now   = first_q ? call_over : rej_q;
  assign byte_over = need_byte > cap_eff;

  // bits are sent MSB first; positions above 7 store zeros
  assign pos      = cnt_q - CntW'(1);
  assign ram_wbit = (pos < CntW'(8)) ? data_q[pos[2:0]] : 1'b0;
  assign ram_we   = (state_q == ST_WRITE);

  msbbuf_ram #(
    .WIDTH (1),
    .DEPTH (STORE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q[AddrW-1:0]),
    .wdata_i (ram_wbit),
    .raddr_i (rp_q[AddrW-1:0]),
    .rdata_o (ram_rbit)
  );

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    rej_d       = rej_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d   = bit_count_i;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        err_d   = StatusOk;
        state_d = ST_DONE;
        if (mode_q == ModeAppend) begin
          if (rej_now) begin
            rej_d = 1'b1;
            err_d = StatusErr;
          end else if (byte_over) begin
            rej_d = 1'b1;
            err_d = StatusErr;
          end else begin
            rej_d = 1'b0;
            if (cnt_q != '0) begin
              state_d = ST_WRITE;
            end
          end
        end else begin
          if (SumW'(cnt_q) > SumW'(MAX_READ_BITS) || need_read > SumW'(wp_q)) begin
            err_d = StatusErr;
          end else if (cnt_q != '0) begin
            state_d = ST_READ;
          end
        end
      end
      ST_WRITE: begin
        wp_d  = wp_q + PtrW'(1);
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        rd_pend_d = 1'b1;
        rp_d      = rp_q + PtrW'(1);
        cnt_d     = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last store bit lands in the accumulator this cycle
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapReset;
      wp_q        <= '0;
      rp_q        <= '0;
      rej_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      rej_q       <= rej_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (capacity_bits_we_i) begin
        cap_q <= capacity_bits_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    err_q <= err_d;
    if (in_acc) begin
      mode_q   <= mode_i;
      data_q   <= data_byte_i;
      first_q  <= first_of_call_i;
      nbytes_q <= bytes_in_call_i;
      acc_q    <= '0;
    end else if (rd_pend_q) begin
      acc_q <= {acc_q[WordW-2:0], ram_rbit};
    end
    if (state_q == ST_PREP) begin
      prod_q <= ProdW'(cnt_q) * ProdW'(nbytes_q);
    end
    if (state_q == ST_DONE && out_free) begin
      status_q <= err_q;
      word_q   <= (err_q == StatusErr) ? '0 : acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign word_o      = word_q;

endmodule : msb_first_bit_stream_buffer_core

`default_nettype wire

@@ src/msbbuf_checker.sv @@
// Port-level checker for the bit stream buffer, bound to the top level.
`default_nettype none

module msbbuf_checker
  import msbbuf_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              status_o,
  input wire logic [WordW-1:0]  word_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(word_o))
    else $error("result changed while stalled");

  // an error never carries data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusErr |-> word_o == '0)
    else $error("error result with nonzero word");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("accepted a second word while busy");

  // a result needs at least the check cycles after accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared right after accept");

endmodule : msbbuf_checker

bind msb_first_bit_stream_buffer_core msbbuf_checker u_msbbuf_checker (.*);

`default_nettype wire
